// ===== rtl/hs_pkg.sv =====
// Heap sorter package: widths, depth, sequencer state and cell control.
// No dependencies; imported by hs_cell and heap_sorter.
`timescale 1ns / 1ps
`default_nettype none

package hs_pkg;

  localparam int unsigned MaxElements = 64;
  localparam int unsigned ValueW      = 32;

  typedef logic signed [ValueW-1:0] value_t;

  typedef enum logic [1:0] {
    StLoad = 2'b01,
    StEmit = 2'b10
  } state_e;

  typedef struct packed {
    logic insert;
    logic shift;
  } hs_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/hs_cell.sv =====
// Heap sorter cell: one sorted slot of the insertion chain.
// Depends on hs_pkg; instantiated in a row by heap_sorter.
`timescale 1ns / 1ps
`default_nettype none

module hs_cell import hs_pkg::*; (
  input  wire      clk_i,
  input  wire      rst_ni,
  input  hs_ctrl_t ctrl_i,
  input  value_t   x_i,
  input  value_t   prev_val_i,
  input  logic     prev_vld_i,
  input  logic     prev_take_i,
  input  value_t   next_val_i,
  input  logic     next_vld_i,
  output value_t   val_o,
  output logic     vld_o,
  output logic     take_o
);

  value_t val_q, val_d;
  logic   vld_q, vld_d;

  assign take_o = !vld_q || (val_q > x_i);
  assign val_o  = val_q;
  assign vld_o  = vld_q;

  always_comb begin
    val_d = val_q;
    vld_d = vld_q;
    if (ctrl_i.insert) begin
      if (take_o) begin
        val_d = prev_take_i ? prev_val_i : x_i;
        vld_d = vld_q | !prev_take_i | prev_vld_i;
      end
    end else if (ctrl_i.shift) begin
      val_d = next_val_i;
      vld_d = next_vld_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

`default_nettype wire

// ===== rtl/heap_sorter.sv =====
// Sorter top level: a chain of MaxElements insertion cells, kept in ascending order.
// Load: input transfers enter the chain; a run closes on last or when the chain fills.
// Emit: results leave the chain head via an output register, one per cycle unless stalled;
// the first passes the state and output registers; the next run loads as the last leaves.
// Reset clears all cell valid bits, the output register valid and returns to loading.
`timescale 1ns / 1ps
`default_nettype none

module heap_sorter import hs_pkg::*; (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic signed [ValueW-1:0] value_i,
  input  logic         last_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic signed [ValueW-1:0] value_res_o,
  output logic         last_res_o
);

  state_e   state_q, state_d;
  hs_ctrl_t ctrl;
  value_t   cell_val  [MaxElements];
  logic     cell_vld  [MaxElements];
  logic     cell_take [MaxElements];

  logic   out_valid_q, out_valid_d;
  value_t out_val_q, out_val_d;
  logic   out_last_q, out_last_d;
  logic   accept, pop, run_end;

  assign in_ready_o = (state_q == StLoad);
  assign accept     = in_valid_i && in_ready_o;
  assign run_end    = last_i || cell_vld[MaxElements-2];
  assign pop        = (state_q == StEmit) && (!out_valid_q || out_ready_i);

  assign ctrl.insert = accept;
  assign ctrl.shift  = pop;

  for (genvar i = 0; i < MaxElements; i++) begin : g_cell
    value_t prev_val, next_val;
    logic   prev_vld, prev_take, next_vld;
    if (i == 0) begin : g_head
      assign prev_val  = value_i;
      assign prev_vld  = 1'b1;
      assign prev_take = 1'b0;
    end else begin : g_body
      assign prev_val  = cell_val[i-1];
      assign prev_vld  = cell_vld[i-1];
      assign prev_take = cell_take[i-1];
    end
    if (i == MaxElements - 1) begin : g_tail
      assign next_val = '0;
      assign next_vld = 1'b0;
    end else begin : g_link
      assign next_val = cell_val[i+1];
      assign next_vld = cell_vld[i+1];
    end
    hs_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .x_i         (value_i),
      .prev_val_i  (prev_val),
      .prev_vld_i  (prev_vld),
      .prev_take_i (prev_take),
      .next_val_i  (next_val),
      .next_vld_i  (next_vld),
      .val_o       (cell_val[i]),
      .vld_o       (cell_vld[i]),
      .take_o      (cell_take[i])
    );
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StLoad: begin
        if (accept && run_end) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (pop && !cell_vld[1]) begin
          state_d = StLoad;
        end
      end
      default: state_d = StLoad;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_val_d   = out_val_q;
    out_last_d  = out_last_q;
    if (pop) begin
      out_valid_d = 1'b1;
      out_val_d   = cell_val[0];
      out_last_d  = !cell_vld[1];
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StLoad;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_val_q  <= out_val_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign value_res_o = out_val_q;
  assign last_res_o  = out_last_q;

  a_emit_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit) |-> cell_vld[0])
    else $error("emit phase with empty chain");

  a_head_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_vld[1] |-> (cell_vld[0] && !(cell_val[0] > cell_val[1])))
    else $error("chain head out of order");

  a_last_starts_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last_i) |=> (state_q == StEmit))
    else $error("closing transfer did not start emission");

  a_no_pop_while_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StLoad) |=> !$rose(out_valid_q) || $past(pop))
    else $error("result raised without a pop");

endmodule

`default_nettype wire
